// ===== design/vtp_pkg.sv =====
// Package for the vertex transform unit: constants, register indexes and
// the control struct shared between the queue and the back end. No dependencies.
package vtp_pkg;

    // Matrix entries are always 16-bit signed fixed point.
    localparam int ENTRY_W = 16;
    localparam int NUM_ROWS = 4;
    localparam int ROW_W = ENTRY_W * NUM_ROWS;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROW_0 = 2'd0;
    localparam logic [1:0] REG_ROW_1 = 2'd1;
    localparam logic [1:0] REG_ROW_2 = 2'd2;
    localparam logic [1:0] REG_ROW_3 = 2'd3;

    // Reset values of the rows: the identity matrix.
    localparam logic [ROW_W-1:0] ROW_0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW_1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW_2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0] ROW_3_RESET = 64'h0100_0000_0000_0000;

    // Operation codes.
    localparam logic OP_POINT  = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    // Control of a request leaving the queue.
    typedef struct packed {
        logic valid;
        logic op;
    } vtp_ctl_t;

endpackage

// ===== design/vtp_front.sv =====
// Front end of the vertex transform: accepts requests and forms the four
// row dot products in a four-stage pipeline. Depends on vtp_pkg.
module vtp_front #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int VW         = 17,
    parameter int SW         = 35
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_op,
    input  logic [3:0][COMP_WIDTH-1:0]             in_vec,
    input  logic [vtp_pkg::NUM_ROWS-1:0][vtp_pkg::ROW_W-1:0] rows,
    output logic                                   push,
    input  logic                                   queue_full,
    output logic [4*SW:0]                          push_data
);

    localparam int PW = vtp_pkg::ENTRY_W + VW;

    logic [3:0] vld_reg;
    logic [3:0] rdy;

    logic                        op0_reg, op1_reg, op2_reg, op3_reg;
    logic [3:0][VW-1:0]          vec_reg;
    logic [3:0][3:0][PW-1:0]     prod_reg;
    logic [3:0][1:0][PW:0]       pair_reg;
    logic [3:0][SW-1:0]          sum_reg;

    // Ready flows back stage by stage so bubbles are squeezed out.
    assign rdy[3]   = !vld_reg[3] || !queue_full;
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign in_ready = rdy[0];
    assign push     = vld_reg[3] && !queue_full;
    assign push_data = {op3_reg, sum_reg};

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // Input stage: sign-extend, and a point gets w = 1.0.
    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            op0_reg <= in_op;
            for (int c = 0; c < 3; c++) begin
                vec_reg[c] <= VW'(signed'(in_vec[c]));
            end
            if (in_op == vtp_pkg::OP_POINT) begin
                vec_reg[3] <= VW'(1) << FRAC_BITS;
            end else begin
                vec_reg[3] <= VW'(signed'(in_vec[3]));
            end
        end
    end

    // Product stage: sixteen matrix-by-component products.
    always_ff @(posedge aclk) begin
        if (rdy[1] && vld_reg[0]) begin
            op1_reg <= op0_reg;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    prod_reg[r][c] <=
                        PW'(signed'(rows[r][vtp_pkg::ENTRY_W*c +: vtp_pkg::ENTRY_W]))
                        * PW'(signed'(vec_reg[c]));
                end
            end
        end
    end

    // Pair sums.
    always_ff @(posedge aclk) begin
        if (rdy[2] && vld_reg[1]) begin
            op2_reg <= op1_reg;
            for (int r = 0; r < 4; r++) begin
                pair_reg[r][0] <= (PW+1)'(signed'(prod_reg[r][0]))
                                + (PW+1)'(signed'(prod_reg[r][1]));
                pair_reg[r][1] <= (PW+1)'(signed'(prod_reg[r][2]))
                                + (PW+1)'(signed'(prod_reg[r][3]));
            end
        end
    end

    // Final dot product sums.
    always_ff @(posedge aclk) begin
        if (rdy[3] && vld_reg[2]) begin
            op3_reg <= op2_reg;
            for (int r = 0; r < 4; r++) begin
                sum_reg[r] <= SW'(signed'(pair_reg[r][0])) + SW'(signed'(pair_reg[r][1]));
            end
        end
    end

endmodule

// ===== design/vtp_queue.sv =====
// Short register queue between the front and back end of the vertex
// transform. Depends on vtp_pkg.
module vtp_queue #(
    parameter int DW = 141
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  logic [DW-1:0]   push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output logic [DW-1:0]   head_data
);

    localparam int AW = $clog2(vtp_pkg::QUEUE_DEPTH);

    logic [DW-1:0] mem_reg [vtp_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full      = count_reg == (AW+1)'(vtp_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/vtp_back.sv =====
// Back end of the vertex transform: rounding, saturation and a pipelined
// restoring divider, one quotient bit per stage. Depends on vtp_pkg.
module vtp_back #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SW         = 35
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  vtp_pkg::vtp_ctl_t           ctl,
    input  logic [3:0][SW-1:0]          sums,
    output logic                        res_valid,
    output logic [3:0][COMP_WIDTH-1:0]  res_vec,
    output logic                        res_zero
);

    localparam int MW   = SW - 1;
    localparam int NW   = MW + FRAC_BITS;
    localparam int QB   = COMP_WIDTH + 1;
    localparam int DW   = MW + QB + FRAC_BITS;
    localparam int SATW = MW + 2;

    typedef struct packed {
        logic                        vld;
        logic                        point;
        logic                        zero;
        logic [2:0]                  neg;
        logic [2:0]                  ovf;
        logic [3:0][COMP_WIDTH-1:0]  rs;
        logic [MW-1:0]               md;
        logic [2:0][NW-1:0]          rem;
        logic [2:0][QB-1:0]          quo;
    } pay_t;

    // Saturate a sign and magnitude to the signed component range.
    function automatic logic [COMP_WIDTH-1:0] sat_out(input logic neg,
                                                      input logic [SATW-1:0] m);
        logic [SATW-1:0] lim;
        logic [SATW-1:0] v;
        lim = SATW'(1) << (COMP_WIDTH - 1);
        v = m;
        if (neg) begin
            if (v > lim) v = lim;
            return COMP_WIDTH'(-v);
        end
        if (v > lim - SATW'(1)) v = lim - SATW'(1);
        return COMP_WIDTH'(v);
    endfunction

    pay_t st_reg [QB+1];
    pay_t head;

    logic [3:0][MW-1:0] mags;
    logic [3:0]         sgn;
    logic [MW:0]        rnd_sum [4];

    // Entry stage: magnitudes, signs, rounded products and overflow checks.
    always_comb begin
        head = '0;
        head.vld   = ctl.valid;
        head.point = ctl.op == vtp_pkg::OP_POINT;
        head.zero  = head.point && (sums[3] == '0);
        for (int c = 0; c < 4; c++) begin
            sgn[c]  = sums[c][SW-1];
            mags[c] = sgn[c] ? MW'(-sums[c]) : MW'(sums[c]);
            rnd_sum[c] = (MW+1)'(mags[c]) + ((MW+1)'(1) << (FRAC_BITS - 1));
            head.rs[c] = sat_out(sgn[c], SATW'(rnd_sum[c] >> FRAC_BITS));
        end
        head.md = mags[3];
        for (int c = 0; c < 3; c++) begin
            head.neg[c] = sgn[c] ^ sgn[3];
            head.rem[c] = {mags[c], {FRAC_BITS{1'b0}}};
            head.ovf[c] = DW'(head.rem[c]) >= (DW'(mags[3]) << QB);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) st_reg[0] <= head;
    end

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < QB; i++) begin : g_div
        localparam int K = QB - 1 - i;
        pay_t nxt;
        always_comb begin
            nxt = st_reg[i];
            for (int c = 0; c < 3; c++) begin
                if (DW'(st_reg[i].rem[c]) >= (DW'(st_reg[i].md) << K)) begin
                    nxt.rem[c] = NW'(DW'(st_reg[i].rem[c]) - (DW'(st_reg[i].md) << K));
                    nxt.quo[c][K] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (advance) st_reg[i+1] <= nxt;
        end
    end

    // Valid bits of the pipeline are cleared by reset (payload is not).
    logic [QB+1:0] vld_unused;
    assign vld_unused = '0;

    pay_t            fin;
    logic [QB:0]     qr;
    logic [SATW-1:0] qm;
    logic [3:0][COMP_WIDTH-1:0] vec_next;
    logic            rbit;
    logic            out_valid_reg;
    logic            out_zero_reg;
    logic [3:0][COMP_WIDTH-1:0] out_vec_reg;
    logic [QB:0]     stage_vld_reg;

    // Final rounding of the quotients and choice of result.
    always_comb begin
        fin = st_reg[QB];
        vec_next = fin.rs;
        for (int c = 0; c < 3; c++) begin
            rbit = {fin.rem[c][MW-1:0], 1'b0} >= {1'b0, fin.md};
            qr   = (QB+1)'(fin.quo[c]) + (QB+1)'(rbit);
            qm   = fin.ovf[c] ? '1 : SATW'(qr);
            if (fin.point) vec_next[c] = sat_out(fin.neg[c], qm);
        end
        if (fin.zero) vec_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            stage_vld_reg <= {stage_vld_reg[QB-1:0], ctl.valid};
            out_valid_reg <= stage_vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_vec_reg  <= vec_next;
            out_zero_reg <= fin.zero;
        end
    end

    assign res_valid = out_valid_reg && (vld_unused == '0);
    assign res_vec   = out_vec_reg;
    assign res_zero  = out_zero_reg;

endmodule

// ===== design/vertex_transform_perspective_unit.sv =====
// Vertex transform by a 4x4 matrix with perspective divide, top level.
// A request passes the four-stage dot-product front end, the queue, the
// bit-per-stage divider and a registered output before its result appears.
// Throughput: one request per cycle; a stalled output halts the back end, and
// the front end runs on until the four-entry queue between them is full.
// Reset (aresetn low, synchronous) empties the pipelines and the queue and
// loads the identity matrix. Uses vtp_pkg, vtp_front, vtp_queue and vtp_back.
module vertex_transform_perspective_unit #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // in_x, in_y, in_z, in_w from the lowest bit up, zero-padded to bytes
    input  logic [((4*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x, out_y, out_z, out_w from the lowest bit up, zero-padded to bytes
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // zero_divisor
    output logic                          m_axis_tuser,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [vtp_pkg::ROW_W-1:0]     cfg_wdata
);

    localparam int TW = ((4*COMP_WIDTH+7)/8)*8;
    localparam int VW = (COMP_WIDTH > FRAC_BITS + 1) ? COMP_WIDTH : FRAC_BITS + 2;
    localparam int SW = vtp_pkg::ENTRY_W + VW + 2;

    logic [vtp_pkg::NUM_ROWS-1:0][vtp_pkg::ROW_W-1:0] rows_reg;

    // Matrix row registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg[0] <= vtp_pkg::ROW_0_RESET;
            rows_reg[1] <= vtp_pkg::ROW_1_RESET;
            rows_reg[2] <= vtp_pkg::ROW_2_RESET;
            rows_reg[3] <= vtp_pkg::ROW_3_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                vtp_pkg::REG_ROW_0: rows_reg[0] <= cfg_wdata;
                vtp_pkg::REG_ROW_1: rows_reg[1] <= cfg_wdata;
                vtp_pkg::REG_ROW_2: rows_reg[2] <= cfg_wdata;
                vtp_pkg::REG_ROW_3: rows_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                      q_push, q_full, q_pop, q_not_empty;
    logic [4*SW:0]             q_in, q_head;
    logic [3:0][COMP_WIDTH-1:0] in_vec, res_vec;
    logic                      res_valid, res_zero, be_adv;
    vtp_pkg::vtp_ctl_t         be_ctl;

    assign in_vec = s_axis_tdata[4*COMP_WIDTH-1:0];

    vtp_front #(
        .COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS), .VW(VW), .SW(SW)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .in_vec(in_vec), .rows(rows_reg),
        .push(q_push), .queue_full(q_full), .push_data(q_in)
    );

    vtp_queue #(.DW(4*SW+1)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_not_empty), .head_data(q_head)
    );

    // The back end moves whenever the output register is free or drains.
    assign be_adv       = !m_axis_tvalid || m_axis_tready;
    assign q_pop        = be_adv && q_not_empty;
    assign be_ctl.valid = q_pop;
    assign be_ctl.op    = q_head[4*SW];

    vtp_back #(
        .COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS), .SW(SW)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .advance(be_adv),
        .ctl(be_ctl), .sums(q_head[4*SW-1:0]),
        .res_valid(res_valid), .res_vec(res_vec), .res_zero(res_zero)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = TW'(res_vec);
    assign m_axis_tuser  = res_zero;

    // A zero divisor result carries all-zero components.
    a_zero_div_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero divisor result with nonzero data");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue overflow");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

// ===== sim/vertex_transform_perspective_unit_checker.sv =====
// Checker for the vertex transform unit: watches both streams, predicts each
// result from the matrix rows and compares in order. Depends on vtp_pkg.
`timescale 1ns / 100ps
module vertex_transform_perspective_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    output int          error_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        logic        zdiv;
        logic [63:0] comps;
    } vertex_t;

    logic [63:0] matrix_rows [4];
    vertex_t     expected_vertices [$];

    // Saturate sign and magnitude to a signed 16-bit component.
    function automatic logic [15:0] clamp16(input bit neg, input longint unsigned m);
        if (neg) begin
            if (m > 64'd32768) m = 64'd32768;
            return 16'(-m);
        end
        if (m > 64'd32767) m = 64'd32767;
        return 16'(m);
    endfunction

    function automatic logic [15:0] round_q8(input longint s);
        longint unsigned m;
        m = (s < 0) ? -s : s;
        m = (m + 128) >> 8;
        return clamp16(s < 0, m);
    endfunction

    function automatic logic [15:0] divide_q8(input longint n, input longint d);
        longint unsigned mn, md, q, r;
        mn = ((n < 0) ? -n : n) << 8;
        md = (d < 0) ? -d : d;
        q = mn / md;
        r = mn % md;
        if (r >= md - r) q++;
        return clamp16(((n < 0) != (d < 0)) && q != 0, q);
    endfunction

    function automatic vertex_t transform_vertex(input logic op, input logic [63:0] v);
        longint comp [4];
        longint dot [4];
        vertex_t res;
        for (int c = 0; c < 4; c++) comp[c] = longint'($signed(v[16*c +: 16]));
        if (op == vtp_pkg::OP_POINT) comp[3] = 256;
        for (int r = 0; r < 4; r++) begin
            dot[r] = 0;
            for (int c = 0; c < 4; c++)
                dot[r] += longint'($signed(matrix_rows[r][16*c +: 16])) * comp[c];
        end
        res = '0;
        if (op == vtp_pkg::OP_POINT && dot[3] == 0) begin
            res.zdiv = 1'b1;
            return res;
        end
        res.comps[63:48] = round_q8(dot[3]);
        for (int r = 0; r < 3; r++)
            res.comps[16*r +: 16] = (op == vtp_pkg::OP_POINT) ? divide_q8(dot[r], dot[3])
                                                              : round_q8(dot[r]);
        return res;
    endfunction

    assign pending_count = expected_vertices.size();

    // Track the matrix, queue predictions on each request, check each result.
    always @(posedge aclk) begin
        vertex_t want;
        if (!aresetn) begin
            matrix_rows[0] <= vtp_pkg::ROW_0_RESET;
            matrix_rows[1] <= vtp_pkg::ROW_1_RESET;
            matrix_rows[2] <= vtp_pkg::ROW_2_RESET;
            matrix_rows[3] <= vtp_pkg::ROW_3_RESET;
            expected_vertices.delete();
            error_count <= 0;
            result_count <= 0;
        end else begin
            if (cfg_wr_en) matrix_rows[cfg_addr] <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_vertices.push_back(transform_vertex(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                result_count <= result_count + 1;
                if (expected_vertices.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_vertices.pop_front();
                    for (int f = 0; f < 4; f++)
                        if (m_axis_tdata[16*f +: 16] !== want.comps[16*f +: 16])
                            $display("%0t: component %0d expected %h actual %h",
                                     $time, f, want.comps[16*f +: 16],
                                     m_axis_tdata[16*f +: 16]);
                    if (m_axis_tdata !== want.comps || m_axis_tuser !== want.zdiv) begin
                        if (m_axis_tuser !== want.zdiv)
                            $display("%0t: zero_divisor expected %b actual %b",
                                     $time, want.zdiv, m_axis_tuser);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/vertex_transform_perspective_unit_tb.sv =====
// Top of the vertex transform testbench: clock, reset, matrix settings and
// request stimulus. Depends on vtp_pkg, the unit and its checker.
`timescale 1ns / 100ps
module vertex_transform_perspective_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    int          error_count;
    int          pending_count;
    int          result_count;
    int          cycle_count;
    bit          calm_phase;
    int          sent_count;

    vertex_transform_perspective_unit DUT (.*);
    vertex_transform_perspective_unit_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side stalls in random bursts until the final calm stretch.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            n = $urandom_range(1, 10);
            m_axis_tready <= calm_phase || ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge aclk);
        end
    end

    function automatic logic [15:0] pick_component();
        unique case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(signed'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // One request; holds tvalid until the unit takes it. Ready is looked at
    // on the falling edge, where it already shows what the next rising edge sees.
    task automatic send_vertex(input logic op, input logic [63:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= v;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        sent_count++;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // One register write, after which the write port goes idle again.
    task automatic write_row(input logic [1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_vertices(input int count);
        for (int i = 0; i < count; i++)
            send_vertex(1'($urandom_range(0, 1)), {pick_component(), pick_component(),
                                                   pick_component(), pick_component()});
    endtask

    function automatic logic [63:0] random_row();
        return {pick_component(), pick_component(), pick_component(), pick_component()};
    endfunction

    initial begin
        calm_phase = 1'b0;
        sent_count = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = vtp_pkg::OP_POINT;
        cfg_wr_en = 1'b0;
        cfg_addr = vtp_pkg::REG_ROW_0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity matrix, field extremes, both operations.
        send_vertex(vtp_pkg::OP_POINT, 64'h0);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h0);
        send_vertex(vtp_pkg::OP_POINT, 64'h8000_8000_8000_8000);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h8000_8000_8000_8000);
        send_vertex(vtp_pkg::OP_POINT, 64'h7FFF_7FFF_7FFF_7FFF);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h7FFF_7FFF_7FFF_7FFF);
        send_vertex(vtp_pkg::OP_VECTOR, 64'hFFFF_0080_FF80_0001);
        drain_results();

        // Row 3 zero: every point hits a zero divisor.
        write_row(vtp_pkg::REG_ROW_3, 64'h0);
        send_vertex(vtp_pkg::OP_POINT, 64'h0000_1234_8000_7FFF);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h0100_1234_8000_7FFF);
        drain_results();

        // Tiny w: w is a single LSB, so the quotients saturate; it still divides.
        write_row(vtp_pkg::REG_ROW_3, 64'h0001_0000_0000_0000);
        write_row(vtp_pkg::REG_ROW_0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_row(vtp_pkg::REG_ROW_1, 64'h8000_8000_8000_8000);
        write_row(vtp_pkg::REG_ROW_2, 64'h0080_FF80_0001_FFFF);
        send_vertex(vtp_pkg::OP_POINT, 64'h0000_0100_0100_0100);
        send_vertex(vtp_pkg::OP_POINT, 64'h0000_FF00_0100_0080);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h7FFF_7FFF_7FFF_7FFF);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h8000_8000_8000_8000);
        drain_results();

        // Rounding close to ties: w = -2.0, odd numerators.
        write_row(vtp_pkg::REG_ROW_3, 64'hFE00_0000_0000_0000);
        write_row(vtp_pkg::REG_ROW_0, 64'h0001_0000_0000_0001);
        send_vertex(vtp_pkg::OP_POINT, 64'h0000_0000_0000_0001);
        send_vertex(vtp_pkg::OP_POINT, 64'h0000_0000_0000_FFFF);
        send_vertex(vtp_pkg::OP_VECTOR, 64'h0080_0000_0000_0080);
        drain_results();

        // Random phases, each with a fresh matrix.
        for (int p = 0; p < 5; p++) begin
            for (int r = 0; r < 4; r++) write_row(r[1:0], random_row());
            if (p == 4) calm_phase = 1'b1;
            random_vertices(120);
            drain_results();
        end

        $display("Sent %0d vertices over nine matrix settings, checked %0d results,",
                 sent_count, result_count);
        $display("covering point divide, zero divisor, saturation and vector products.");
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/vtp_pkg.sv
design/vtp_front.sv
design/vtp_queue.sv
design/vtp_back.sv
design/vertex_transform_perspective_unit.sv
sim/vertex_transform_perspective_unit_checker.sv
sim/vertex_transform_perspective_unit_tb.sv
